@@ design/assert_macros.svh @@
// Assertion macros shared by the cache core modules.
// Depends on nothing; included by the files that carry assertions.
// Assertions compile only in simulation builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ design/lkvc_pkg.sv @@
// Shared types and constants of the key-value cache core.
// Depends on nothing; used by every module of the core.
package lkvc_pkg;

   // Field widths and default geometry.
   localparam int LKVC_MAX_ENTRIES = 16;
   localparam int LKVC_KEY_W       = 32;
   localparam int LKVC_VALUE_W     = 32;
   localparam int LKVC_CAP_W       = 5;

   localparam logic [LKVC_CAP_W-1:0]   LKVC_CAP_RESET  = 5'd16;
   localparam logic [LKVC_VALUE_W-1:0] LKVC_MISS_VALUE = '1;

   // Operation codes of an incoming transaction.
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // capture the request and begin the lookup scan
      logic commit;   // apply the hit or insert decision and begin the update scan
      logic respond;  // load the result register
   } lkvc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done; // last entry of the running scan has been processed
      logic op_put;    // captured transaction is a put
      logic hit;       // lookup found the key
      logic rsp_free;  // result register can take a new result this cycle
   } lkvc_status_type;

endpackage

@@ design/lkvc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on lkvc_pkg for default sizes.
module lkvc_ram
   import lkvc_pkg::*;
#(
   parameter int WIDTH  = LKVC_KEY_W,
   parameter int DEPTH  = LKVC_MAX_ENTRIES,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lkvc_ctrl.sv @@
// Controller state machine of the cache core: sequences lookup, decision,
// update and response. Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lkvc_status_type status,
   output lkvc_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // A get that misses changes nothing and goes straight to its result.
            if (status.hit || status.op_put) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_UPDATE: begin
            if (status.scan_done) begin
               state_in = status.op_put ? ST_IDLE : ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_DECIDE: begin
            cmd.commit = status.hit || status.op_put;
         end
         ST_RESPOND: begin
            cmd.respond = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A started transaction always begins with the lookup scan.
   `ASSERT_AT(a_start_enters_lookup, clock, reset, cmd.start |=> state_ff == ST_LOOKUP)
   // Scans only finish while the controller waits for one.
   `ASSERT_NEVER(a_done_outside_scan, clock, reset,
                 status.scan_done && !(state_ff == ST_LOOKUP || state_ff == ST_UPDATE))
   // A put never produces a result.
   `ASSERT_AT(a_put_no_result, clock, reset, state_ff == ST_RESPOND |-> !status.op_put)

endmodule

@@ design/lkvc_datapath.sv @@
// Datapath of the cache core: entry memories, scan counter, lookup trackers,
// occupancy, capacity register and result register.
// Depends on lkvc_pkg, lkvc_ram and assert_macros.svh.
`include "assert_macros.svh"
module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lkvc_cmd_type                   cmd,
   output lkvc_status_type                status,
   input  logic                           req_op,
   input  logic signed [LKVC_KEY_W-1:0]   req_key,
   input  logic signed [LKVC_VALUE_W-1:0] req_value,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic signed [LKVC_VALUE_W-1:0] rsp_read_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [LKVC_CAP_W-1:0]          csr_capacity
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > LKVC_CAP_W) ? CNT_W : LKVC_CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   // Captured transaction.
   logic                    op_ff;
   logic [LKVC_KEY_W-1:0]   key_ff;
   logic [LKVC_VALUE_W-1:0] value_ff;

   // Configuration and occupancy.
   logic [LKVC_CAP_W-1:0]   capacity_ff, capacity_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic [MAX_ENTRIES-1:0]  valid_ff, valid_in;

   // Scan sequencing.
   logic                    scan_ff, scan_in;
   logic                    upd_ff, upd_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    dv_ff, dv_in;
   logic                    last_ff, last_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   // Lookup trackers.
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]        hit_rank_ff, hit_rank_in;
   logic [LKVC_VALUE_W-1:0] hit_value_ff, hit_value_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        victim_idx_ff, victim_idx_in;

   // Update pass control.
   logic [IDX_W-1:0]        target_ff, target_in;
   logic [CNT_W-1:0]        thr_ff, thr_in;
   logic                    ins_ff, ins_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [LKVC_VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   // Memory ports.
   logic [LKVC_KEY_W-1:0]   key_rd;
   logic [LKVC_VALUE_W-1:0] value_rd;
   logic [IDX_W-1:0]        rank_rd;
   logic [IDX_W-1:0]        rank_new;
   logic                    key_we, value_we, rank_we;

   // Working signals.
   logic                    entry_valid;
   logic                    lookup_dv;
   logic                    full;
   logic [CMP_W-1:0]        cap_eff;
   logic [IDX_W-1:0]        slot;

   assign csr_ready   = 1'b1;
   assign entry_valid = valid_ff[idx_ff];
   assign lookup_dv   = dv_ff && !upd_ff;

   // Capacity as used: zero behaves as one, anything above the store size as the size.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity_ff) > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CMP_W'(capacity_ff);
      end
   end

   assign full = CMP_W'(occ_ff) >= cap_eff;

   // Insert slot: the first free entry, or when full the lower of victim and first free entry.
   always_comb begin
      if (!full) begin
         slot = free_idx_ff;
      end else if (free_found_ff && (free_idx_ff < victim_idx_ff)) begin
         slot = free_idx_ff;
      end else begin
         slot = victim_idx_ff;
      end
   end

   // Rank rewrite of the update pass: target becomes newest, younger entries age.
   always_comb begin
      if (idx_ff == target_ff) begin
         rank_new = '0;
      end else if (entry_valid && (CNT_W'(rank_rd) < thr_ff)) begin
         rank_new = rank_rd + IDX_W'(1);
      end else begin
         rank_new = rank_rd;
      end
   end

   assign rank_we  = dv_ff && upd_ff;
   assign key_we   = rank_we && (idx_ff == target_ff) && ins_ff;
   assign value_we = rank_we && (idx_ff == target_ff) && (op_ff == OP_PUT);

   // Scan sequencing: one entry address issued per cycle, its data in the cycle after.
   always_comb begin
      scan_in = scan_ff;
      upd_in  = upd_ff;
      cnt_in  = cnt_ff;
      dv_in   = scan_ff;
      last_in = scan_ff && (cnt_ff == LAST_IDX);
      idx_in  = cnt_ff;
      if (cmd.start || cmd.commit) begin
         scan_in = 1'b1;
         upd_in  = cmd.commit;
         cnt_in  = '0;
      end else if (scan_ff) begin
         if (cnt_ff == LAST_IDX) begin
            scan_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + IDX_W'(1);
         end
      end
   end

   // Lookup trackers: first hit, first free entry and oldest valid entry.
   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      victim_idx_in = victim_idx_ff;
      if (cmd.start) begin
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (lookup_dv) begin
         if (entry_valid && (key_rd == key_ff) && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = idx_ff;
            hit_rank_in  = rank_rd;
            hit_value_in = value_rd;
         end
         if (!entry_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
         if (entry_valid && (CNT_W'(rank_rd) == (occ_ff - CNT_W'(1)))) begin
            victim_idx_in = idx_ff;
         end
      end
   end

   // Decision: touch a hit, or evict when full and insert into the chosen slot.
   always_comb begin
      target_in = target_ff;
      thr_in    = thr_ff;
      ins_in    = ins_ff;
      occ_in    = occ_ff;
      valid_in  = valid_ff;
      if (cmd.commit) begin
         if (hit_ff) begin
            target_in = hit_idx_ff;
            thr_in    = CNT_W'(hit_rank_ff);
            ins_in    = 1'b0;
         end else begin
            target_in = slot;
            thr_in    = occ_ff;
            ins_in    = 1'b1;
            if (full) begin
               valid_in[victim_idx_ff] = 1'b0;
            end else begin
               occ_in = occ_ff + CNT_W'(1);
            end
            valid_in[slot] = 1'b1;
         end
      end
   end

   // Configuration register and result register.
   always_comb begin
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity;
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         rsp_value_in = hit_ff ? hit_value_ff : LKVC_MISS_VALUE;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= LKVC_CAP_RESET;
         occ_ff       <= '0;
         valid_ff     <= '0;
         scan_ff      <= 1'b0;
         upd_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         upd_ff       <= upd_in;
         dv_ff        <= dv_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      victim_idx_ff <= victim_idx_in;
      target_ff     <= target_in;
      thr_ff        <= thr_in;
      ins_ff        <= ins_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Entry memories share the scan read address.
   lkvc_ram #(
      .WIDTH (LKVC_KEY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (cnt_ff),
      .rd_data (key_rd)
   );

   lkvc_ram #(
      .WIDTH (LKVC_VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (idx_ff),
      .wr_data (value_ff),
      .rd_addr (cnt_ff),
      .rd_data (value_rd)
   );

   lkvc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ENTRIES)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (idx_ff),
      .wr_data (rank_new),
      .rd_addr (cnt_ff),
      .rd_data (rank_rd)
   );

   // Status and outputs.
   assign status.scan_done = dv_ff && last_ff;
   assign status.op_put    = (op_ff == OP_PUT);
   assign status.hit       = hit_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // Occupancy always matches the number of valid entries.
   `ASSERT_AT(a_occ_matches_valid, clock, reset, $countones(valid_ff) == int'(occ_ff))
   // Occupancy never exceeds the store size.
   `ASSERT_AT(a_occ_bounded, clock, reset, int'(occ_ff) <= MAX_ENTRIES)
   // A key is only written into an entry already marked valid.
   `ASSERT_AT(a_key_write_valid, clock, reset, key_we |-> entry_valid)

endmodule

@@ design/lru_key_value_cache_core.sv @@
// LRU key-value cache; one transaction is in flight at a time.
// A lookup scans the entry memories one entry per cycle; hits and puts add a rank update scan.
// A get that misses raises rsp_valid after its lookup scan; one that hits, after its update scan.
// A put raises no rsp_valid and returns to idle when its update scan is done.
// Synchronous reset empties the store and sets capacity to 16; no clearing pass is needed.
module lru_key_value_cache_core
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic signed [LKVC_KEY_W-1:0]   req_key,
   input  logic signed [LKVC_VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic signed [LKVC_VALUE_W-1:0] rsp_read_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [LKVC_CAP_W-1:0]          csr_capacity
);

   lkvc_cmd_type    cmd;
   lkvc_status_type status;

   // Sequencing of each transaction.
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, lookup and result path.
   lkvc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

endmodule
